// ----- rtl/adie_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adie_pkg
// Shared types, constants and saturation helpers of the adaptive inertia and
// damping estimator.
// ----------------------------------------------------------------------------
package adie_pkg;

  localparam int DW      = 32;          // word width
  localparam int FB      = 16;          // fraction bits
  localparam int MW      = DW + 1;      // multiplier operand width
  localparam int PW      = 2 * MW;      // full product width
  localparam int AW      = DW + 3;      // accumulator width (five terms)
  localparam int NUMW    = DW + FB;     // dividend width
  localparam int DENW    = DW - 1;      // divisor width
  localparam int CFG_IW  = 4;           // config index width
  localparam int NLAM    = 4;
  localparam int TSW     = 17;          // time step width

  localparam logic [CFG_IW-1:0] CFG_LAMBDA_EFFORT    = 4'd0;
  localparam logic [CFG_IW-1:0] CFG_LAMBDA_QUADRATIC = 4'd1;
  localparam logic [CFG_IW-1:0] CFG_LAMBDA_LINEAR    = 4'd2;
  localparam logic [CFG_IW-1:0] CFG_LAMBDA_OFFSET    = 4'd3;
  localparam logic [CFG_IW-1:0] CFG_OBSERVER_GAIN    = 4'd4;
  localparam logic [CFG_IW-1:0] CFG_TIME_STEP        = 4'd5;
  localparam logic [CFG_IW-1:0] CFG_MIN_ALPHA        = 4'd6;
  localparam logic [CFG_IW-1:0] CFG_INITIAL_ALPHA    = 4'd7;

  localparam logic [DENW-1:0]      RST_LAMBDA   = 31'd65536;
  localparam logic signed [DW-1:0] RST_OBS_GAIN = -32'sd65536;
  localparam logic [TSW-1:0]       RST_TSTEP    = 17'd655;
  localparam logic [DENW-1:0]      RST_MIN_ALPHA = 31'd66;
  localparam logic [DENW-1:0]      RST_INIT_ALPHA = 31'd65536;

  localparam logic signed [DW-1:0] FX_ONE = DW'(1) << FB;

  localparam logic signed [PW-1:0] WMAX_P = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [PW-1:0] WMIN_P = {{(PW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_ISSUE,
    ST_MUL_WB,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } adie_state_e;

  typedef enum logic [4:0] {
    U_R1, U_AOG, U_AP0, U_AP1, U_AP2, U_AP3,
    U_G0, U_D0, U_U0,
    U_G1, U_D1, U_U1,
    U_G2, U_D2, U_U2,
    U_G3, U_D3, U_U3,
    U_VE
  } adie_uop_e;

  typedef struct packed {
    logic signed [DW-1:0] effort;
    logic signed [DW-1:0] measured_velocity;
  } adie_in_t;

  typedef struct packed {
    logic [DW-2:0]        inertia;
    logic signed [DW-1:0] quadratic_damping;
    logic signed [DW-1:0] linear_damping;
    logic signed [DW-1:0] buoyancy;
    logic signed [DW-1:0] velocity_error;
  } adie_out_t;

  typedef struct packed {
    logic [CFG_IW-1:0] index;
    logic [DW-1:0]     data;
  } adie_cfg_t;

  // Clamp a wide signed value into the word range.
  function automatic logic signed [DW-1:0] sat_word(input logic signed [PW-1:0] x);
    logic signed [DW-1:0] r;
    if (x > WMAX_P) begin
      r = WMAX_P[DW-1:0];
    end else if (x < WMIN_P) begin
      r = WMIN_P[DW-1:0];
    end else begin
      r = x[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [MW-1:0] ext_mw(input logic signed [DW-1:0] x);
    return {x[DW-1], x};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/adie_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adie_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface adie_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/adie_fxmul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adie_fxmul
// Shared fixed point multiplier: registered product, round half up, saturate.
// ----------------------------------------------------------------------------
module adie_fxmul
  import adie_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic signed [MW-1:0] a_i,
  input  wire logic signed [MW-1:0] b_i,
  output logic signed [DW-1:0]      res_o
);

  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] shr;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  always_comb begin
    rnd   = prod_q + (PW'(1) <<< (FB - 1));
    shr   = rnd >>> FB;
    res_o = sat_word(shr);
  end

endmodule
`default_nettype wire

// ----- rtl/adie_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adie_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module adie_div
  import adie_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NUMW-1:0] num_i,
  input  wire logic [DENW-1:0] den_i,
  output logic                 done_o,
  output logic [NUMW-1:0]      quo_o
);

  localparam int CW = $clog2(NUMW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CW-1:0]   cnt_q;
  logic [NUMW-1:0] quo_q;
  logic [DENW-1:0] rem_q;
  logic [DENW-1:0] den_q;
  logic [DENW:0]   rem_sh;
  logic            ge;
  logic [DENW:0]   diff;

  always_comb begin
    rem_sh = {rem_q, quo_q[NUMW-1]};
    ge     = rem_sh >= {1'b0, den_q};
    diff   = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUMW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUMW-2:0], ge};
      rem_q <= ge ? diff[DENW-1:0] : rem_sh[DENW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ----- rtl/adaptive_inertia_damping_estimator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_inertia_damping_estimator
// Lyapunov-type adaptive identifier of inertia, damping and buoyancy.
// ----------------------------------------------------------------------------
// Each input transfer carries one effort and one measured velocity sample
// (signed Q16.16). The block updates its velocity estimate and the four
// entry parameter vector phi, then returns one result transfer with the
// velocity error and inertia = 1/alpha, quadratic and linear damping and
// buoyancy = -phi_i/alpha, all saturated. The 19 multiplies of one item
// share one 33x33 multiplier, then four divisions share one bit-serial
// divider. Input ready is high only while idle; a finished result sits in
// an output register so the next item can be accepted while it waits.
// Configuration writes are always taken; writing initial_alpha reloads phi
// (alpha, 0, 0, 0) and keeps the velocity estimate.
// ----------------------------------------------------------------------------
module adaptive_inertia_damping_estimator
  import adie_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  adie_stream_if.sink   in_i,
  adie_stream_if.source out_o,
  adie_stream_if.sink   cfg_i
);

  adie_state_e state_q, state_d;
  adie_uop_e   step_q, step_d;
  logic [1:0]  dsel_q, dsel_d;

  // configuration
  logic [DENW-1:0]      lam_q [NLAM];
  logic signed [DW-1:0] og_q;
  logic [TSW-1:0]       dt_q;
  logic [DENW-1:0]      mina_q;

  // estimator state
  logic signed [DW-1:0] ve_q;
  logic signed [DW-1:0] phi_q [NLAM];

  // per-item scratch
  logic signed [DW-1:0] err_q;
  logic signed [DW-1:0] eff_q;
  logic signed [DW-1:0] r1_q;
  logic signed [AW-1:0] acc_q;
  logic signed [DW-1:0] t_q;
  logic [DW-2:0]        inv_q;
  logic signed [DW-1:0] dq_q [1:3];

  adie_out_t out_q;
  logic      out_valid_q;

  logic in_acc;
  logic in_ready;
  logic div_start;

  logic [1:0]           lane;
  logic [1:0]           idx;
  logic signed [DW-1:0] phi_rd;
  logic [DENW-1:0]      lam_rd;
  logic signed [DW-1:0] reg_rd;
  logic signed [MW-1:0] ve_abs;
  logic signed [DW-1:0] acc_sat;
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [DW-1:0] mul_res;
  logic signed [MW-1:0] neg_res;
  logic signed [MW-1:0] err_new;

  logic [DENW-1:0]      mina_eff;
  logic [DENW-1:0]      alpha;
  logic signed [MW-1:0] phi_neg;
  logic [DW-1:0]        phi_mag;
  logic                 phi_pos;
  logic [NUMW-1:0]      div_num;
  logic                 div_done;
  logic [NUMW-1:0]      div_quo;

  localparam logic [NUMW-1:0] DIV_ONE  = NUMW'(1) << (2 * FB);
  localparam logic [NUMW-1:0] Q_POSMAX = (NUMW'(1) << (DW - 1)) - NUMW'(1);
  localparam logic [NUMW-1:0] Q_NEGMAX = NUMW'(1) << (DW - 1);

  assign in_acc = in_i.valid && in_ready;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dsel_d  = dsel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_MUL_ISSUE;
          step_d  = U_R1;
        end
      end
      ST_MUL_ISSUE: state_d = ST_MUL_WB;
      ST_MUL_WB: begin
        if (step_q == U_VE) begin
          state_d = ST_DIV_START;
          dsel_d  = '0;
        end else begin
          state_d = ST_MUL_ISSUE;
          step_d  = adie_uop_e'(step_q + 5'd1);
        end
      end
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (dsel_q == 2'd3) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_DIV_START;
            dsel_d  = dsel_q + 2'd1;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_q == ST_IDLE);
    div_start = (state_q == ST_DIV_START);
  end

  // ------------------------------------------------------- operand selection
  always_comb begin
    unique case (step_q) inside
      U_AP1, U_G1, U_D1, U_U1: lane = 2'd1;
      U_AP2, U_G2, U_D2, U_U2: lane = 2'd2;
      U_AP3, U_G3, U_D3, U_U3: lane = 2'd3;
      default:                 lane = 2'd0;
    endcase
  end

  assign idx    = (state_q == ST_DIV_START || state_q == ST_DIV_WAIT) ? dsel_q : lane;
  assign phi_rd = phi_q[idx];
  assign lam_rd = lam_q[lane];

  always_comb begin
    case (idx)
      2'd0:    reg_rd = eff_q;
      2'd1:    reg_rd = r1_q;
      2'd2:    reg_rd = ve_q;
      default: reg_rd = FX_ONE;
    endcase
  end

  assign ve_abs  = ve_q[DW-1] ? -ext_mw(ve_q) : ext_mw(ve_q);
  assign acc_sat = sat_word(PW'(acc_q));

  always_comb begin
    case (step_q) inside
      U_R1: begin
        mul_a = ext_mw(ve_q);
        mul_b = ve_abs;
      end
      U_AOG: begin
        mul_a = ext_mw(og_q);
        mul_b = ext_mw(err_q);
      end
      U_AP0, U_AP1, U_AP2, U_AP3: begin
        mul_a = ext_mw(phi_rd);
        mul_b = ext_mw(reg_rd);
      end
      U_G0, U_G1, U_G2, U_G3: begin
        mul_a = {2'b00, lam_rd};
        mul_b = ext_mw(err_q);
      end
      U_D0, U_D1, U_D2, U_D3: begin
        mul_a = ext_mw(t_q);
        mul_b = ext_mw(reg_rd);
      end
      U_U0, U_U1, U_U2, U_U3: begin
        mul_a = ext_mw(t_q);
        mul_b = {{(MW-TSW){1'b0}}, dt_q};
      end
      U_VE: begin
        mul_a = ext_mw(acc_sat);
        mul_b = {{(MW-TSW){1'b0}}, dt_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  adie_fxmul u_fxmul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  assign neg_res = -ext_mw(mul_res);
  assign err_new = ext_mw(ve_q) - ext_mw(in_i.payload.measured_velocity);

  // --------------------------------------------------------------- divisions
  // Alpha never drops below one LSB, so the divider never sees zero.
  always_comb begin
    mina_eff = (mina_q == '0) ? DENW'(1) : mina_q;
    alpha    = (phi_q[0] > $signed({1'b0, mina_eff})) ? phi_q[0][DENW-1:0] : mina_eff;
    phi_neg  = -ext_mw(phi_rd);
    phi_mag  = phi_rd[DW-1] ? phi_neg[DW-1:0] : phi_rd;
    phi_pos  = !phi_rd[DW-1] && (phi_rd != '0);
    div_num  = (dsel_q == 2'd0) ? DIV_ONE : {phi_mag, {FB{1'b0}}};
  end

  adie_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (alpha),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // ------------------------------------------------- control and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= U_R1;
      dsel_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NLAM; i++) begin
        lam_q[i] <= RST_LAMBDA;
      end
      og_q     <= RST_OBS_GAIN;
      dt_q     <= RST_TSTEP;
      mina_q   <= RST_MIN_ALPHA;
      ve_q     <= '0;
      phi_q[0] <= {1'b0, RST_INIT_ALPHA};
      phi_q[1] <= '0;
      phi_q[2] <= '0;
      phi_q[3] <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      dsel_q  <= dsel_d;

      // hold the result until the sink takes it
      if (state_q == ST_OUT && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      // phi and velocity writeback from the shared multiplier
      if (state_q == ST_MUL_WB) begin
        case (step_q) inside
          U_U0, U_U1, U_U2, U_U3:
            phi_q[lane] <= sat_word(PW'(ext_mw(phi_rd) + ext_mw(mul_res)));
          U_VE:
            ve_q <= sat_word(PW'(ext_mw(ve_q) + ext_mw(mul_res)));
          default: ;
        endcase
      end

      if (cfg_i.valid) begin
        unique case (cfg_i.payload.index) inside
          CFG_LAMBDA_EFFORT, CFG_LAMBDA_QUADRATIC, CFG_LAMBDA_LINEAR, CFG_LAMBDA_OFFSET:
            lam_q[cfg_i.payload.index[1:0]] <= cfg_i.payload.data[DENW-1:0];
          CFG_OBSERVER_GAIN: og_q   <= cfg_i.payload.data;
          CFG_TIME_STEP:     dt_q   <= cfg_i.payload.data[TSW-1:0];
          CFG_MIN_ALPHA:     mina_q <= cfg_i.payload.data[DENW-1:0];
          CFG_INITIAL_ALPHA: begin
            phi_q[0] <= {1'b0, cfg_i.payload.data[DENW-1:0]};
            phi_q[1] <= '0;
            phi_q[2] <= '0;
            phi_q[3] <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // ----------------------------------------------------------------- scratch
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_q <= sat_word(PW'(err_new));
      eff_q <= in_i.payload.effort;
    end

    if (state_q == ST_MUL_WB) begin
      case (step_q) inside
        U_R1:                       r1_q  <= mul_res;
        U_AOG:                      acc_q <= AW'(mul_res);
        U_AP0, U_AP1, U_AP2, U_AP3: acc_q <= acc_q + AW'(mul_res);
        U_G0, U_G1, U_G2, U_G3:     t_q   <= mul_res;
        U_D0, U_D1, U_D2, U_D3:     t_q   <= sat_word(PW'(neg_res));
        default: ;
      endcase
    end

    // truncate toward zero on magnitudes, then restore sign and saturate
    if (state_q == ST_DIV_WAIT && div_done) begin
      if (dsel_q == 2'd0) begin
        inv_q <= (div_quo > Q_POSMAX) ? Q_POSMAX[DW-2:0] : div_quo[DW-2:0];
      end else if (phi_pos) begin
        dq_q[dsel_q] <= (div_quo > Q_NEGMAX) ? WMIN_P[DW-1:0] : -div_quo[DW-1:0];
      end else begin
        dq_q[dsel_q] <= (div_quo > Q_POSMAX) ? WMAX_P[DW-1:0] : div_quo[DW-1:0];
      end
    end

    if (state_q == ST_OUT && (!out_valid_q || out_o.ready)) begin
      out_q.inertia           <= inv_q;
      out_q.quadratic_damping <= dq_q[1];
      out_q.linear_damping    <= dq_q[2];
      out_q.buoyancy          <= dq_q[3];
      out_q.velocity_error    <= err_q;
    end
  end

  assign in_i.ready    = in_ready;
  assign cfg_i.ready   = 1'b1;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule
`default_nettype wire

// ----- rtl/adie_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adie_assert
// Port level checks of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
module adie_assert
  import adie_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_i,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire adie_out_t out_payload_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_payload_i))
    else $error("result changed while stalled");

  // one item at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // no result can appear the cycle after a transfer in
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result too early");

endmodule

bind adaptive_inertia_damping_estimator adie_assert u_adie_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
`default_nettype wire
